[rtl/sre_pkg.sv]
// Shared types, opcodes and constants for the simple RISC execute step.
`timescale 1ns / 1ps
package sre_pkg;

    localparam int MEM_WORDS   = 65536;
    localparam int NUM_REGS    = 8;
    localparam int REG_AW      = $clog2(NUM_REGS);
    localparam int XLEN        = 32;
    localparam int PC_W        = 16;
    localparam int IMM_W       = 16;
    localparam int OPC_W       = 5;
    localparam int SHAMT_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 104;

    localparam logic [PC_W-1:0] ADDR_MASK = PC_W'(MEM_WORDS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OPC_W-1:0] OP_ADD = 5'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 5'd1;
    localparam logic [OPC_W-1:0] OP_LSF = 5'd2;
    localparam logic [OPC_W-1:0] OP_RSF = 5'd3;
    localparam logic [OPC_W-1:0] OP_AND = 5'd4;
    localparam logic [OPC_W-1:0] OP_OR  = 5'd5;
    localparam logic [OPC_W-1:0] OP_XOR = 5'd6;
    localparam logic [OPC_W-1:0] OP_LHI = 5'd7;
    localparam logic [OPC_W-1:0] OP_LD  = 5'd8;
    localparam logic [OPC_W-1:0] OP_ST  = 5'd9;
    localparam logic [OPC_W-1:0] OP_JLT = 5'd16;
    localparam logic [OPC_W-1:0] OP_JLE = 5'd17;
    localparam logic [OPC_W-1:0] OP_JEQ = 5'd18;
    localparam logic [OPC_W-1:0] OP_JNE = 5'd19;
    localparam logic [OPC_W-1:0] OP_JIN = 5'd20;
    localparam logic [OPC_W-1:0] OP_HLT = 5'd24;

    typedef enum logic [2:0] {
        K_NOP, K_ALU, K_LHI, K_STORE, K_BRANCH, K_JIN, K_HALT
    } kind_t;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SRA, ALU_AND, ALU_OR, ALU_XOR
    } alu_op_t;

    typedef enum logic [1:0] {
        BR_LT, BR_LE, BR_EQ, BR_NE
    } br_cond_t;

    typedef struct packed {
        kind_t             kind;
        alu_op_t           alu_op;
        br_cond_t          cond;
        logic [REG_AW-1:0] dst;
        logic [REG_AW-1:0] src0;
        logic [REG_AW-1:0] src1;
        logic [IMM_W-1:0]  imm;
    } decoded_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              st_valid;
        logic [PC_W-1:0]   st_addr;
        logic [XLEN-1:0]   st_data;
        logic              rw_valid;
        logic [REG_AW-1:0] rw_index;
        logic [XLEN-1:0]   rw_data;
    } result_t;

endpackage

[rtl/simple_risc_execute_step.sv]
// Top level of the simple RISC execute step: decode front end, queue, execute back end.
`timescale 1ns / 1ps
// Executes one instruction word per transfer and returns one result per transfer.
// Sustained rate is one instruction per clock while the output is not stalled; an
// input transfer reaches the result through the decode register, the queue and the
// result register. The rate is set by the execute stage, which reads and updates the
// 8-entry register file and the program counter as each instruction is accepted, so
// dependent instructions issue back to back. After a halt, every further
// instruction returns the held program counter with halted set and no writes.
module simple_risc_execute_step
    import sre_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // [31:0] instruction
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] next_pc, [16] halted, [17] store_valid, [33:18] store_addr,
    // [65:34] store_data, [66] reg_write_valid, [69:67] reg_write_index,
    // [101:70] reg_write_data, [103:102] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    decoded_t dec_op;
    logic     dec_valid;
    logic     dec_ready;
    decoded_t q_op;
    logic     q_valid;
    logic     q_ready;
    result_t  res;

    sre_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (s_axis_tdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_op    (dec_op),
        .out_valid (dec_valid),
        .out_ready (dec_ready)
    );

    sre_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (dec_op),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .out_op    (q_op),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    sre_execute u_execute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (q_op),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .out_res   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, res.rw_data, res.rw_index, res.rw_valid, res.st_data,
                           res.st_addr, res.st_valid, res.halted, res.next_pc};

endmodule

[rtl/sre_decode.sv]
// Front end: accepts instruction words and classifies them into decoded operations.
`timescale 1ns / 1ps
module sre_decode
    import sre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_TDATA_W-1:0] in_word,
    input  logic                  in_valid,
    output logic                  in_ready,
    output decoded_t              out_op,
    output logic                  out_valid,
    input  logic                  out_ready
);

    decoded_t         op_reg;
    decoded_t         op_next;
    logic             valid_reg;
    logic             valid_next;
    logic [OPC_W-1:0] opcode;

    assign opcode   = in_word[29:25];
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        op_next        = op_reg;
        valid_next     = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next     = 1'b1;
            op_next.kind   = K_NOP;
            op_next.alu_op = ALU_ADD;
            op_next.cond   = BR_LT;
            op_next.dst    = in_word[24:22];
            op_next.src0   = in_word[21:19];
            op_next.src1   = in_word[18:16];
            op_next.imm    = in_word[15:0];
            case (opcode)
                OP_ADD: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_ADD;
                end
                OP_SUB: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_SUB;
                end
                OP_LSF: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_SLL;
                end
                OP_RSF: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_SRA;
                end
                OP_AND: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_AND;
                end
                OP_OR: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_OR;
                end
                OP_XOR: begin
                    op_next.kind   = K_ALU;
                    op_next.alu_op = ALU_XOR;
                end
                OP_LHI: op_next.kind = K_LHI;
                OP_ST:  op_next.kind = K_STORE;
                OP_JLT: begin
                    op_next.kind = K_BRANCH;
                    op_next.cond = BR_LT;
                end
                OP_JLE: begin
                    op_next.kind = K_BRANCH;
                    op_next.cond = BR_LE;
                end
                OP_JEQ: begin
                    op_next.kind = K_BRANCH;
                    op_next.cond = BR_EQ;
                end
                OP_JNE: begin
                    op_next.kind = K_BRANCH;
                    op_next.cond = BR_NE;
                end
                OP_JIN: op_next.kind = K_JIN;
                OP_HLT: op_next.kind = K_HALT;
                OP_LD:  op_next.kind = K_NOP;
                default: op_next.kind = K_NOP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        op_reg <= op_next;
    end

    assign out_op    = op_reg;
    assign out_valid = valid_reg;

endmodule

[rtl/sre_queue.sv]
// Short FIFO of decoded operations between the front end and the execute stage.
`timescale 1ns / 1ps
module sre_queue
    import sre_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  decoded_t in_op,
    input  logic     in_valid,
    output logic     in_ready,
    output decoded_t out_op,
    output logic     out_valid,
    input  logic     out_ready
);

    decoded_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

[rtl/sre_execute.sv]
// Back end: register file, program counter, ALU and branch unit, registered result.
`timescale 1ns / 1ps
module sre_execute
    import sre_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  decoded_t in_op,
    input  logic     in_valid,
    output logic     in_ready,
    output result_t  out_res,
    output logic     out_valid,
    input  logic     out_ready
);

    logic [XLEN-1:0]   regs_reg [NUM_REGS];
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic              halt_reg;
    logic              halt_next;
    result_t           res_reg;
    result_t           res_next;
    logic              res_valid_reg;
    logic              res_valid_next;

    logic              fire;
    logic [REG_AW-1:0] rd_a_idx;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    logic [XLEN-1:0]   alu_val;
    logic [PC_W-1:0]   pc_plus;
    logic              taken;
    logic              wr;
    logic [XLEN-1:0]   wr_val;

    assign in_ready = !res_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign rd_a_idx = (in_op.kind == K_LHI) ? in_op.dst : in_op.src0;
    assign op_a     = (rd_a_idx == '0) ? '0 : regs_reg[rd_a_idx];
    assign op_b     = (in_op.src1 == '0) ? '0 : regs_reg[in_op.src1];
    assign pc_plus  = pc_reg + PC_W'(1);

    always_comb begin
        case (in_op.alu_op)
            ALU_ADD: alu_val = op_a + op_b;
            ALU_SUB: alu_val = op_a - op_b;
            ALU_SLL: alu_val = op_a << op_b[SHAMT_W-1:0];
            ALU_SRA: alu_val = XLEN'($signed(op_a) >>> op_b[SHAMT_W-1:0]);
            ALU_AND: alu_val = op_a & op_b;
            ALU_OR:  alu_val = op_a | op_b;
            ALU_XOR: alu_val = op_a ^ op_b;
            default: alu_val = op_a + op_b;
        endcase
    end

    always_comb begin
        case (in_op.cond)
            BR_LT:   taken = $signed(op_a) < $signed(op_b);
            BR_LE:   taken = $signed(op_a) <= $signed(op_b);
            BR_EQ:   taken = op_a == op_b;
            BR_NE:   taken = op_a != op_b;
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        wr             = 1'b0;
        wr_val         = alu_val;
        if (out_ready) begin
            res_valid_next = 1'b0;
        end
        if (fire) begin
            res_valid_next = 1'b1;
            res_next       = '0;
            if (!halt_reg) begin
                pc_next = pc_plus;
                case (in_op.kind)
                    K_ALU: wr = 1'b1;
                    K_LHI: begin
                        wr     = 1'b1;
                        wr_val = {in_op.imm, op_a[IMM_W-1:0]};
                    end
                    K_STORE: begin
                        res_next.st_valid = 1'b1;
                        res_next.st_addr  = op_b[PC_W-1:0] & ADDR_MASK;
                        res_next.st_data  = op_a;
                    end
                    K_BRANCH: begin
                        if (taken) begin
                            pc_next = in_op.imm;
                        end
                    end
                    K_JIN: pc_next = op_a[PC_W-1:0];
                    K_HALT: begin
                        halt_next = 1'b1;
                        pc_next   = pc_reg;
                    end
                    default: pc_next = pc_plus;
                endcase
                if (wr && in_op.dst != '0) begin
                    res_next.rw_valid = 1'b1;
                    res_next.rw_index = in_op.dst;
                    res_next.rw_data  = wr_val;
                end
            end
            res_next.next_pc = pc_next;
            res_next.halted  = halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
        end else begin
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            res_valid_reg <= res_valid_next;
            if (res_next.rw_valid && fire) begin
                regs_reg[res_next.rw_index] <= res_next.rw_data;
            end
        end
        res_reg <= res_next;
    end

    assign out_res   = res_reg;
    assign out_valid = res_valid_reg;

endmodule

[rtl/sre_checker.sv]
// Port-level checker for the simple RISC execute step, bound to the top level.
`timescale 1ns / 1ps
module sre_checker
    import sre_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    logic            m_xfer;
    logic            halt_seen_reg;
    logic [PC_W-1:0] halt_pc_reg;

    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg <= 1'b0;
        end else if (m_xfer && m_axis_tdata[16] && !halt_seen_reg) begin
            halt_seen_reg <= 1'b1;
        end
        if (m_xfer && m_axis_tdata[16] && !halt_seen_reg) begin
            halt_pc_reg <= m_axis_tdata[15:0];
        end
    end

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && halt_seen_reg |-> m_axis_tdata[16] && m_axis_tdata[15:0] == halt_pc_reg)
        else $error("halted result lost halt state or held pc");

    a_halt_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && m_axis_tdata[16] |-> !m_axis_tdata[17] && !m_axis_tdata[66])
        else $error("halted result carries a write");

    a_store_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && !m_axis_tdata[17] |-> m_axis_tdata[65:18] == '0)
        else $error("store fields not zero without store");

    a_regwr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> (m_axis_tdata[66] ? m_axis_tdata[69:67] != '0
                                     : m_axis_tdata[101:67] == '0))
        else $error("register write fields inconsistent");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind simple_risc_execute_step sre_checker u_sre_checker (.*);
